// ===== rtl/gaussian_blur_3x3_clamped_core_defines.svh =====
// assertion macros used by the blur core checker
`ifndef GAUSSIAN_BLUR_3X3_CLAMPED_CORE_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_CLAMPED_CORE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define GBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbc check failed");

// next-cycle implication, off while reset is low
`define GBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbc check failed");

// what must hold in the cycle after a reset cycle
`define GBC_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("gbc reset check failed");

`endif

// ===== rtl/gbc_pkg.sv =====
// types, constants and helper functions of the 3x3 blur core
`default_nettype none

package gbc_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int ACC_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = COEF_W + PIX_W;
    localparam int ROUND_HALF = 128;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_SLOTS  = 3;
    localparam int SLOT_W     = 2;

    localparam int HEIGHT_CAP = 2048;
    localparam int HW         = 12;
    localparam int RW         = 11;

    localparam int WIDTH_RESET  = 1100;
    localparam int HEIGHT_RESET = 720;
    localparam logic [COEF_W-1:0] CENTER_RESET = 16'd13382;
    localparam logic [COEF_W-1:0] EDGE_RESET   = 16'd8114;
    localparam logic [COEF_W-1:0] CORNER_RESET = 16'd4922;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_EDGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER  = 3'd4;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

    typedef enum logic [1:0] {
        KIND_CORNER,
        KIND_EDGE,
        KIND_CENTER
    } t_tap_kind;

    localparam t_tap_kind TAP_KIND [NUM_TAPS] = '{
        KIND_CORNER, KIND_EDGE,   KIND_CORNER,
        KIND_EDGE,   KIND_CENTER, KIND_EDGE,
        KIND_CORNER, KIND_EDGE,   KIND_CORNER
    };

    // one column of the row store: one byte per row slot
    typedef logic [NUM_SLOTS-1:0][PIX_W-1:0] t_col_word;
    typedef logic [NUM_TAPS-1:0][PIX_W-1:0]  t_taps;

    // what the tap select stage needs besides the read data
    typedef struct packed {
        logic                         parity;
        logic                         c0_self;
        logic                         c2_self;
        logic [2:0][SLOT_W-1:0]       slot;
        logic [2:0]                   subst;
        logic [PIX_W-1:0]             pix;
        logic                         last;
    } t_tap_ctl;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 2'd1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_LAST : s - 2'd1;
    endfunction

    // one multiply-accumulate with round to nearest and saturation
    function automatic logic [ACC_W-1:0] mac_step(input logic [ACC_W-1:0]  s,
                                                  input logic [COEF_W-1:0] coef,
                                                  input logic [PIX_W-1:0]  pix);
        logic [PROD_W-1:0] prod;
        logic [ACC_W-1:0]  inc;
        logic [ACC_W:0]    sum;
        prod = PROD_W'(coef) * PROD_W'(pix);
        inc  = ACC_W'((prod + PROD_W'(ROUND_HALF)) >> FRAC_W);
        sum  = (ACC_W+1)'(s) + (ACC_W+1)'(inc);
        return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gaussian_blur_3x3_clamped_core.sv =====
// 3x3 blur of a gray raster stream with replicated borders
//
// s_* channel takes one command beat per cycle: tuser 0 pushes the pixel in
// tdata, tuser 1 drains one pending result after the last pixel of a frame.
// m_* channel returns blurred pixels in raster order, tlast on the final pixel
// of each frame. The result for pixel n is produced by the push of pixel
// n + width + 1 (or by a drain beat). Unless m_tready stalls, throughput is
// one beat per cycle on both sides. Three image rows live in two
// column banks (even and odd columns, one byte lane per row slot) with two
// read ports each, so one push writes one byte and reads the three columns
// of a 3x3 window in the same cycle; nine multiply-accumulate stages follow.
// Configuration is written through i_cfg_* while no beat is in flight.
// Reset clears counters and pipeline valids and restores the register
// defaults; the row stores are not cleared and need no clearing pass.
// When m_tready is low the pipeline fills its empty stages and keeps taking
// beats; s_tready drops only once all 11 stages hold a result.
`default_nettype none

module gaussian_blur_3x3_clamped_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // pixel_in
    input  wire logic                              s_tuser,   // command
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // pixel_out
    output logic                                   m_tlast,
    input  wire logic                              i_cfg_we,
    input  wire logic [gbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gbc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int PW         = $clog2(MAX_WIDTH + 2);
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int RST_WIDTH  = (gbc_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                MAX_WIDTH : gbc_pkg::WIDTH_RESET;
    localparam int NT         = gbc_pkg::NUM_TAPS;
    localparam int HW         = gbc_pkg::HW;
    localparam int RW         = gbc_pkg::RW;

    // configuration
    logic [WW-1:0]                   r_width;
    logic [HW-1:0]                   r_height;
    logic [gbc_pkg::COEF_W-1:0]      r_coef_center;
    logic [gbc_pkg::COEF_W-1:0]      r_coef_edge;
    logic [gbc_pkg::COEF_W-1:0]      r_coef_corner;
    logic [11:0]                     cfg_d12;

    // stream position
    logic [CW-1:0]                   r_in_col, n_in_col;
    logic [RW-1:0]                   r_in_row, n_in_row;
    logic [gbc_pkg::SLOT_W-1:0]      r_in_slot, n_in_slot;
    logic [CW-1:0]                   r_out_col, n_out_col;
    logic [RW-1:0]                   r_out_row, n_out_row;
    logic [gbc_pkg::SLOT_W-1:0]      r_out_slot, n_out_slot;
    logic [PW-1:0]                   r_pending, n_pending;
    logic                            r_draining, n_draining;

    logic                            accept;
    logic                            is_drain;
    logic                            drain_ok;
    logic                            emit_push;
    logic                            emit;
    logic [WW-1:0]                   in_col_inc;
    logic                            in_col_wrap;
    logic [HW-1:0]                   in_row_inc;
    logic                            in_row_wrap;
    logic [WW-1:0]                   out_col_inc;
    logic                            out_col_wrap;
    logic [HW-1:0]                   out_row_inc;
    logic                            out_row_wrap;

    // window addressing
    logic [WW-1:0]                   cc_w;
    logic [CW-1:0]                   cc;
    logic [CW-1:0]                   col0;
    logic [CW-1:0]                   col2;
    logic                            subst;
    gbc_pkg::t_tap_ctl               ctl_in;
    logic [AW-1:0]                   addr_cc, addr_c0, addr_c2;
    logic [AW-1:0]                   rd_addr_e0, rd_addr_o0;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;

    // row store banks and read registers
    gbc_pkg::t_col_word              r_bank_even [BANK_DEPTH];
    gbc_pkg::t_col_word              r_bank_odd  [BANK_DEPTH];
    gbc_pkg::t_col_word              r_rd_e0, r_rd_e1, r_rd_o0, r_rd_o1;
    gbc_pkg::t_tap_ctl               r_ctl;
    logic                            r_v_rd;

    // tap select and accumulate pipeline
    gbc_pkg::t_col_word              word_col [3];
    gbc_pkg::t_taps                  taps_sel;
    logic [NT:0]                     r_v;
    logic [NT:0]                     stage_rdy;
    logic                            stage_rdy_rd;
    gbc_pkg::t_taps                  r_tap  [NT];
    logic [gbc_pkg::ACC_W-1:0]       r_acc  [1:NT];
    logic [gbc_pkg::ACC_W-1:0]       n_acc  [1:NT];
    logic                            r_last [NT+1];
    logic [gbc_pkg::COEF_W-1:0]      tap_coef [NT];

    assign cfg_d12 = i_cfg_data[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= WW'(RST_WIDTH);
            r_height      <= HW'(gbc_pkg::HEIGHT_RESET);
            r_coef_center <= gbc_pkg::CENTER_RESET;
            r_coef_edge   <= gbc_pkg::EDGE_RESET;
            r_coef_corner <= gbc_pkg::CORNER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbc_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= (cfg_d12 == '0) ? WW'(1) :
                               ({1'b0, cfg_d12} > 13'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                               WW'(cfg_d12);
                end
                gbc_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= (cfg_d12 == '0) ? HW'(1) :
                                (cfg_d12 > HW'(gbc_pkg::HEIGHT_CAP)) ?
                                HW'(gbc_pkg::HEIGHT_CAP) : cfg_d12;
                end
                gbc_pkg::REG_COEF_CENTER: r_coef_center <= i_cfg_data;
                gbc_pkg::REG_COEF_EDGE:   r_coef_edge   <= i_cfg_data;
                gbc_pkg::REG_COEF_CORNER: r_coef_corner <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign accept    = s_tvalid && s_tready;
    assign is_drain  = (s_tuser == gbc_pkg::CMD_DRAIN);
    assign drain_ok  = (r_pending != '0) && (r_in_col == '0) && (r_in_row == '0);
    assign emit_push = !r_draining && (r_pending >= (PW'(r_width) + PW'(1)));
    assign emit      = accept && (is_drain ? drain_ok : emit_push);

    assign in_col_inc   = WW'(r_in_col) + WW'(1);
    assign in_col_wrap  = in_col_inc >= r_width;
    assign in_row_inc   = HW'(r_in_row) + HW'(1);
    assign in_row_wrap  = in_row_inc >= r_height;
    assign out_col_inc  = WW'(r_out_col) + WW'(1);
    assign out_col_wrap = out_col_inc >= r_width;
    assign out_row_inc  = HW'(r_out_row) + HW'(1);
    assign out_row_wrap = out_row_inc >= r_height;

    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_slot  = r_in_slot;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;
        n_pending  = r_pending;
        n_draining = r_draining;
        if (accept) begin
            if (is_drain) begin
                if (drain_ok) begin
                    n_pending  = r_pending - PW'(1);
                    n_draining = 1'b1;
                end
            end else begin
                if (r_draining) begin
                    n_out_col  = '0;
                    n_out_row  = '0;
                    n_out_slot = r_in_slot;
                    n_draining = 1'b0;
                    n_pending  = PW'(1);
                end else if (!emit_push) begin
                    n_pending = r_pending + PW'(1);
                end
                if (in_col_wrap) begin
                    n_in_col  = '0;
                    n_in_slot = gbc_pkg::slot_next(r_in_slot);
                    n_in_row  = in_row_wrap ? '0 : RW'(in_row_inc);
                end else begin
                    n_in_col = CW'(in_col_inc);
                end
            end
            if (emit) begin
                if (out_col_wrap) begin
                    n_out_col  = '0;
                    n_out_slot = gbc_pkg::slot_next(r_out_slot);
                    n_out_row  = out_row_wrap ? '0 : RW'(out_row_inc);
                end else begin
                    n_out_col = CW'(out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_pending  <= '0;
            r_draining <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_slot  <= n_in_slot;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
            r_pending  <= n_pending;
            r_draining <= n_draining;
        end
    end

    // window columns, clamped at the left and right edges
    assign cc_w  = (WW'(r_out_col) >= r_width) ? (r_width - WW'(1)) : WW'(r_out_col);
    assign cc    = CW'(cc_w);
    assign col0  = (cc != '0) ? (cc - CW'(1)) : cc;
    assign col2  = ((cc_w + WW'(1)) < r_width) ? (cc + CW'(1)) : cc;
    assign subst = !is_drain && (r_in_slot == gbc_pkg::slot_next(r_out_slot));

    always_comb begin
        ctl_in.parity   = cc[0];
        ctl_in.c0_self  = (col0 == cc);
        ctl_in.c2_self  = (col2 == cc);
        ctl_in.slot[0]  = (r_out_row != '0) ? gbc_pkg::slot_prev(r_out_slot) : r_out_slot;
        ctl_in.slot[1]  = r_out_slot;
        ctl_in.slot[2]  = out_row_wrap ? r_out_slot : gbc_pkg::slot_next(r_out_slot);
        ctl_in.subst[0] = !out_row_wrap && subst && (col0 == r_in_col);
        ctl_in.subst[1] = !out_row_wrap && subst && (cc == r_in_col);
        ctl_in.subst[2] = !out_row_wrap && subst && (col2 == r_in_col);
        ctl_in.pix      = s_tdata;
        ctl_in.last     = out_row_wrap && out_col_wrap;
    end

    assign addr_cc    = AW'(cc >> 1);
    assign addr_c0    = AW'(col0 >> 1);
    assign addr_c2    = AW'(col2 >> 1);
    assign rd_addr_e0 = cc[0] ? addr_c0 : addr_cc;
    assign rd_addr_o0 = cc[0] ? addr_cc : addr_c0;
    assign wr_en      = accept && !is_drain;
    assign wr_addr    = AW'(r_in_col >> 1);

    // read-first: a window read sees the store before this beat's write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_e0 <= r_bank_even[rd_addr_e0];
            r_rd_e1 <= r_bank_even[addr_c2];
            r_rd_o0 <= r_bank_odd[rd_addr_o0];
            r_rd_o1 <= r_bank_odd[addr_c2];
            r_ctl   <= ctl_in;
        end
        if (wr_en && !r_in_col[0]) begin
            r_bank_even[wr_addr][r_in_slot] <= s_tdata;
        end
        if (wr_en && r_in_col[0]) begin
            r_bank_odd[wr_addr][r_in_slot] <= s_tdata;
        end
    end

    // ready runs back from the output register
    always_comb begin
        stage_rdy[NT] = !r_v[NT] || m_tready;
        for (int k = NT - 1; k >= 0; k--) begin
            stage_rdy[k] = !r_v[k] || stage_rdy[k+1];
        end
        stage_rdy_rd = !r_v_rd || stage_rdy[0];
    end

    assign s_tready = stage_rdy_rd;

    always_comb begin
        word_col[1] = r_ctl.parity ? r_rd_o0 : r_rd_e0;
        word_col[0] = r_ctl.c0_self ? word_col[1] : (r_ctl.parity ? r_rd_e0 : r_rd_o0);
        word_col[2] = r_ctl.c2_self ? word_col[1] : (r_ctl.parity ? r_rd_e1 : r_rd_o1);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                taps_sel[r*3+c] = word_col[c][r_ctl.slot[r]];
                if (r == 2 && r_ctl.subst[c]) begin
                    taps_sel[r*3+c] = r_ctl.pix;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            unique case (gbc_pkg::TAP_KIND[k])
                gbc_pkg::KIND_CENTER: tap_coef[k] = r_coef_center;
                gbc_pkg::KIND_EDGE:   tap_coef[k] = r_coef_edge;
                gbc_pkg::KIND_CORNER: tap_coef[k] = r_coef_corner;
                default:              tap_coef[k] = r_coef_corner;
            endcase
        end
    end

    always_comb begin
        n_acc[1] = gbc_pkg::mac_step('0, tap_coef[0], r_tap[0][0]);
        for (int k = 2; k <= NT; k++) begin
            n_acc[k] = gbc_pkg::mac_step(r_acc[k-1], tap_coef[k-1], r_tap[k-1][k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rd <= 1'b0;
            r_v    <= '0;
        end else begin
            if (stage_rdy_rd) begin
                r_v_rd <= emit;
            end
            if (stage_rdy[0]) begin
                r_v[0] <= r_v_rd;
            end
            for (int k = 1; k <= NT; k++) begin
                if (stage_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_tap[0]  <= taps_sel;
            r_last[0] <= r_ctl.last;
        end
        for (int k = 1; k <= NT; k++) begin
            if (stage_rdy[k]) begin
                r_acc[k]  <= n_acc[k];
                r_last[k] <= r_last[k-1];
            end
        end
        for (int k = 1; k < NT; k++) begin
            if (stage_rdy[k]) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign m_tvalid = r_v[NT];
    assign m_tdata  = r_acc[NT][gbc_pkg::ACC_W-1:gbc_pkg::FRAC_W];
    assign m_tlast  = r_last[NT];

endmodule

`default_nettype wire

// ===== rtl/gbc_checker.sv =====
// port-level checks of the blur core, bound to the top level
`default_nettype none
`include "gaussian_blur_3x3_clamped_core_defines.svh"

module gbc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    `GBC_ASSERT_RST(a_rst_no_result, i_clk, i_rst_n, !m_tvalid)

    `GBC_ASSERT_RST(a_rst_ready, i_clk, i_rst_n, s_tready)

    // the input side only waits when every stage is full and the output stalls
    `GBC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_tready, m_tvalid && !m_tready)

    `GBC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind gaussian_blur_3x3_clamped_core gbc_checker u_gbc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the 3x3 clamped blur core: directed and random frames
module testbench;

    localparam int MAX_W         = 2048;
    localparam int PIPE_SLACK    = 16;
    localparam int IDLE_GUARD    = 20000;
    localparam int RANDOM_PUSHES = 250;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } blur_out_t;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           s_tvalid   = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata    = '0;    // pixel_in
    logic                           s_tuser    = 1'b0;  // command
    logic                           m_tvalid;
    logic                           m_tready   = 1'b0;
    logic [7:0]                     m_tdata;            // pixel_out
    logic                           m_tlast;            // frame_last
    logic                           i_cfg_we   = 1'b0;
    logic [gbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [gbc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int idle_pct = 13;
    int fail_count;
    int push_count;
    int drain_count;
    int result_count;
    int setting_count;

    // predictor state
    logic [11:0] cfg_width;
    logic [11:0] cfg_height;
    logic [15:0] k_center;
    logic [15:0] k_edge;
    logic [15:0] k_corner;
    logic [7:0]  line_rows [3][MAX_W];
    int unsigned in_col, in_row, in_slot;
    int unsigned out_col, out_row, out_slot;
    int unsigned owed;
    bit          draining;
    blur_out_t   blur_expected [$];

    gaussian_blur_3x3_clamped_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > gbc_pkg::HEIGHT_CAP) return gbc_pkg::HEIGHT_CAP;
        return cfg_height;
    endfunction

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // blurs the pixel at the output position and advances the output counters
    function automatic blur_out_t next_result(input int unsigned w, input int unsigned h,
                                              input bit subst, input logic [7:0] pix);
        int unsigned cc;
        int unsigned cols [3];
        int unsigned slots [3];
        int          r;
        int          c;
        logic [15:0] sum;
        logic [15:0] wt;
        logic [7:0]  p;
        logic [63:0] acc;
        blur_out_t   res;
        cc       = (out_col >= w) ? w - 1 : out_col;
        cols[0]  = (cc >= 1) ? cc - 1 : cc;
        cols[1]  = cc;
        cols[2]  = (cc + 1 < w) ? cc + 1 : cc;
        slots[0] = (out_row > 0) ? (out_slot + 2) % 3 : out_slot;
        slots[1] = out_slot;
        slots[2] = (out_row + 1 < h) ? (out_slot + 1) % 3 : out_slot;
        sum = '0;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                if (r == 1 && c == 1) wt = k_center;
                else if (r == 1 || c == 1) wt = k_edge;
                else wt = k_corner;
                // bottom row pixel not yet stored comes from the beat itself
                if (r == 2 && out_row + 1 < h && subst && cols[c] == in_col) p = pix;
                else p = line_rows[slots[r]][cols[c]];
                acc = ((64'(sum) << 8) + 64'(wt) * 64'(p) + 64'd128) >> 8;
                sum = (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
            end
        end
        res.pix  = sum[15:8];
        res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        out_col++;
        if (out_col >= w) begin
            out_col  = 0;
            out_slot = (out_slot + 1) % 3;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
        return res;
    endfunction

    task automatic blur_predict(input logic cmd, input logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        w = eff_width();
        h = eff_height();
        if (cmd == gbc_pkg::CMD_DRAIN) begin
            drain_count++;
            if (owed > 0 && in_col == 0 && in_row == 0) begin
                blur_expected.push_back(next_result(w, h, 1'b0, 8'd0));
                owed--;
                draining = 1'b1;
            end
        end else begin
            push_count++;
            if (draining) begin
                owed     = 0;
                out_col  = 0;
                out_row  = 0;
                out_slot = in_slot;
                draining = 1'b0;
            end
            if (owed >= w + 1)
                blur_expected.push_back(next_result(w, h, in_slot == (out_slot + 1) % 3, pix));
            else
                owed++;
            line_rows[in_slot][in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col  = 0;
                in_slot = (in_slot + 1) % 3;
                in_row++;
                if (in_row >= h) in_row = 0;
            end
        end
    endtask

    task automatic predictor_reset();
        cfg_width  = gbc_pkg::WIDTH_RESET;
        cfg_height = gbc_pkg::HEIGHT_RESET;
        k_center   = gbc_pkg::CENTER_RESET;
        k_edge     = gbc_pkg::EDGE_RESET;
        k_corner   = gbc_pkg::CORNER_RESET;
        in_col     = 0;
        in_row     = 0;
        in_slot    = 0;
        out_col    = 0;
        out_row    = 0;
        out_slot   = 0;
        owed       = 0;
        draining   = 1'b0;
    endtask

    // entered and left just after a falling edge
    task automatic send_beat(input logic cmd, input logic [7:0] pix);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        do @(posedge i_clk); while (!s_tready);
        blur_predict(cmd, pix);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (blur_expected.size() != 0 && guard < IDLE_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_SLACK) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [gbc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            gbc_pkg::REG_IMAGE_WIDTH:  cfg_width  = val[11:0];
            gbc_pkg::REG_IMAGE_HEIGHT: cfg_height = val[11:0];
            gbc_pkg::REG_COEF_CENTER:  k_center   = val;
            gbc_pkg::REG_COEF_EDGE:    k_edge     = val;
            gbc_pkg::REG_COEF_CORNER:  k_corner   = val;
            default: ;
        endcase
    endtask

    task automatic new_setting(input logic [11:0] w, h, input logic [15:0] kc, ke, kk);
        wait_idle();
        write_reg(gbc_pkg::REG_IMAGE_WIDTH, 16'(w));
        write_reg(gbc_pkg::REG_IMAGE_HEIGHT, 16'(h));
        write_reg(gbc_pkg::REG_COEF_CENTER, kc);
        write_reg(gbc_pkg::REG_COEF_EDGE, ke);
        write_reg(gbc_pkg::REG_COEF_CORNER, kk);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic push_pixels(input int unsigned n);
        repeat (n) send_beat(gbc_pkg::CMD_PUSH, random_pixel());
    endtask

    task automatic push_frame();
        push_pixels(eff_width() * eff_height());
    endtask

    task automatic finish_frame();
        while (in_col != 0 || in_row != 0) send_beat(gbc_pkg::CMD_PUSH, random_pixel());
    endtask

    task automatic drain_all();
        while (owed > 0) send_beat(gbc_pkg::CMD_DRAIN, random_pixel());
    endtask

    task automatic push_noisy_frame();
        int unsigned left;
        left = eff_width() * eff_height();
        while (left > 0) begin
            if ($urandom_range(0, 99) < 4) begin
                send_beat(gbc_pkg::CMD_DRAIN, random_pixel());
            end else begin
                send_beat(gbc_pkg::CMD_PUSH, random_pixel());
                left--;
            end
        end
    endtask

    // also fills every row slot so later reduced sizes read written columns
    task automatic test_small_frame();
        new_setting(12'd4, 12'd3, gbc_pkg::CENTER_RESET, gbc_pkg::EDGE_RESET,
                    gbc_pkg::CORNER_RESET);
        send_beat(gbc_pkg::CMD_PUSH, 8'd0);
        send_beat(gbc_pkg::CMD_PUSH, 8'd255);
        finish_frame();
        drain_all();
    endtask

    task automatic test_counter_wrap();
        new_setting(12'd4, 12'd3, rand_coef(), rand_coef(), rand_coef());
        push_pixels(3);
        new_setting(12'd2, 12'd2, rand_coef(), rand_coef(), rand_coef());
        finish_frame();
        drain_all();
    endtask

    task automatic test_degenerate_sizes();
        new_setting(12'd0, 12'd0, rand_coef(), rand_coef(), rand_coef());
        push_pixels(1);
        drain_all();
        push_pixels(3);
        drain_all();
    endtask

    task automatic test_stray_drains();
        new_setting(12'd3, 12'd2, rand_coef(), rand_coef(), rand_coef());
        send_beat(gbc_pkg::CMD_DRAIN, 8'd0);
        push_pixels(2);
        send_beat(gbc_pkg::CMD_DRAIN, 8'd255);
        finish_frame();
        send_beat(gbc_pkg::CMD_DRAIN, 8'd0);
        send_beat(gbc_pkg::CMD_DRAIN, 8'd0);
        push_frame();
        drain_all();
        send_beat(gbc_pkg::CMD_DRAIN, 8'd0);
    endtask

    task automatic test_saturation();
        new_setting(12'd3, 12'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (9) send_beat(gbc_pkg::CMD_PUSH, 8'd255);
        drain_all();
        push_frame();
        drain_all();
        new_setting(12'd3, 12'd3, 16'h0000, 16'h0000, 16'h0000);
        push_frame();
        drain_all();
    endtask

    task automatic test_streaming();
        new_setting(12'd5, 12'd2, rand_coef(), rand_coef(), rand_coef());
        repeat (3) push_frame();
        drain_all();
    endtask

    task automatic test_no_idle_stretch();
        idle_pct = 0;
        new_setting(12'd24, 12'd3, rand_coef(), rand_coef(), rand_coef());
        repeat (2) push_frame();
        drain_all();
        wait_idle();
        idle_pct = 13;
    endtask

    task automatic test_random_frames();
        int unsigned start_pushes;
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        start_pushes = push_count;
        while (push_count - start_pushes < RANDOM_PUSHES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 5);
                end
                6, 7, 8: begin
                    w = $urandom_range(9, 40);
                    h = $urandom_range(1, 4);
                end
                default: begin
                    w = $urandom_range(41, 160);
                    h = $urandom_range(1, 2);
                end
            endcase
            new_setting(12'(w), 12'(h), rand_coef(), rand_coef(), rand_coef());
            repeat ($urandom_range(1, 3)) begin
                push_noisy_frame();
                case ($urandom_range(0, 3))
                    0: ;  // run straight into the next frame
                    1: begin
                        cut = (owed > 0) ? $urandom_range(1, owed) : 0;
                        repeat (cut) send_beat(gbc_pkg::CMD_DRAIN, random_pixel());
                    end
                    default: drain_all();
                endcase
            end
            drain_all();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        blur_out_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            result_count++;
            if (blur_expected.size() == 0) begin
                $error("pixel_out %0d arrived with nothing expected", m_tdata);
                fail_count++;
            end else begin
                want = blur_expected.pop_front();
                if (m_tdata !== want.pix) begin
                    $error("pixel_out expected %0d actual %0d", want.pix, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("frame_last expected %0d actual %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        predictor_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_small_frame();
        test_counter_wrap();
        test_degenerate_sizes();
        test_stray_drains();
        test_saturation();
        test_streaming();
        test_random_frames();
        test_no_idle_stretch();
        wait_idle();
        if (blur_expected.size() != 0) begin
            $error("%0d blurred pixels never came out", blur_expected.size());
            fail_count++;
        end
        $display("sent %0d pixel pushes and %0d drain beats across %0d register settings",
                 push_count, drain_count, setting_count);
        $display("checked %0d blurred pixels incl. streamed, drained and clamped-size frames",
                 result_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4000000;
        $error("run did not complete in time");
        $display("== FAIL ==");
        $finish;
    end

endmodule
